// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the grid visibility block.
// Depends on nothing; the macros compile to nothing when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/glv_pkg.sv =====
// Package of the grid visibility block: sizes, codes, CORDIC table and the
// command and status types between controller and datapath. Depends on nothing.
package glv_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int RAY_COUNT    = 120;
  localparam int RANGE_STEPS  = 12;

  localparam int GRID_CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W       = $clog2(GRID_CELLS);
  localparam int DIM_W        = 9;
  localparam int WSAT_W       = $clog2(MAX_WIDTH + 1);
  localparam int HSAT_W       = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int CPM_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam int RAY_W        = $clog2(RAY_COUNT);
  localparam int REM_W        = $clog2(RAY_COUNT) + 1;
  localparam int STEP_W       = $clog2(RANGE_STEPS + 1);
  localparam logic [63:0] FULL_TURN = 64'h1_0000_0000;
  localparam logic [31:0] ANG_STEP  = 32'(FULL_TURN / RAY_COUNT);
  localparam logic [REM_W-1:0] ANG_REM = REM_W'(FULL_TURN % RAY_COUNT);

  localparam int CORDIC_STEPS = 24;
  localparam int K_W          = $clog2(CORDIC_STEPS);
  localparam int CX_W         = 34;
  localparam int DIR_W        = 18;
  localparam logic [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);
  localparam logic [CX_W-1:0] ROUND_HALF  = CX_W'(8192);
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int POS_W        = 34;
  localparam int PROD_W       = POS_W + CPM_W + 1;
  localparam int GX_W         = PROD_W - 32;

  localparam logic [1:0] VIS_UNKNOWN = 2'd0;
  localparam logic [1:0] VIS_FREE    = 2'd1;
  localparam logic [1:0] VIS_OCC     = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_POSE   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH     = 3'd0,
    CFG_HEIGHT    = 3'd1,
    CFG_ORIGIN_X  = 3'd2,
    CFG_ORIGIN_Y  = 3'd3,
    CFG_CPM       = 3'd4,
    CFG_MAP_VALID = 3'd5
  } cfg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_READ, ST_RAY_INIT, ST_ROTATE,
    ST_DIR, ST_MUL, ST_INDEX, ST_FETCH, ST_MARK, ST_DONE
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic pose_start;
    logic ray_init;
    logic rotate;
    logic dir;
    logic mul;
    logic index;
    logic advance;
    logic ray_next;
    logic load_write;
    logic mark;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    req_e req_type;
    logic map_valid;
    logic cordic_last;
    logic inb;
    logic stop;
    logic last_step;
    logic last_ray;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/glv_ctrl.sv =====
// Controller of the grid visibility block: sequences clearing, loads, reads
// and ray casting. Depends on glv_pkg.
module glv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  glv_pkg::status_t sts_i,
  output glv_pkg::cmd_t    cmd_o
);

  glv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glv_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      glv_pkg::ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = glv_pkg::ST_IDLE;
        end
      end
      glv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = glv_pkg::ST_DISPATCH;
        end
      end
      glv_pkg::ST_DISPATCH: begin
        unique case (sts_i.req_type)
          glv_pkg::REQ_LOAD: state_d = glv_pkg::ST_LOAD;
          glv_pkg::REQ_READ: state_d = glv_pkg::ST_READ;
          glv_pkg::REQ_POSE: begin
            if (sts_i.map_valid) begin
              cmd_o.pose_start = 1'b1;
              state_d          = glv_pkg::ST_RAY_INIT;
            end else begin
              state_d = glv_pkg::ST_DONE;
            end
          end
          default: state_d = glv_pkg::ST_DONE;
        endcase
      end
      glv_pkg::ST_LOAD: begin
        cmd_o.load_write = 1'b1;
        state_d          = glv_pkg::ST_DONE;
      end
      glv_pkg::ST_READ: begin
        state_d = glv_pkg::ST_DONE;
      end
      glv_pkg::ST_RAY_INIT: begin
        cmd_o.ray_init = 1'b1;
        state_d        = glv_pkg::ST_ROTATE;
      end
      glv_pkg::ST_ROTATE: begin
        cmd_o.rotate = 1'b1;
        if (sts_i.cordic_last) begin
          state_d = glv_pkg::ST_DIR;
        end
      end
      glv_pkg::ST_DIR: begin
        cmd_o.dir = 1'b1;
        state_d   = glv_pkg::ST_MUL;
      end
      glv_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = glv_pkg::ST_INDEX;
      end
      glv_pkg::ST_INDEX: begin
        cmd_o.index = 1'b1;
        state_d     = glv_pkg::ST_FETCH;
      end
      glv_pkg::ST_FETCH: begin
        if (sts_i.inb) begin
          state_d = glv_pkg::ST_MARK;
        end else if (sts_i.last_ray) begin
          state_d = glv_pkg::ST_DONE;
        end else begin
          cmd_o.ray_next = 1'b1;
          state_d        = glv_pkg::ST_RAY_INIT;
        end
      end
      glv_pkg::ST_MARK: begin
        cmd_o.mark = 1'b1;
        if (!sts_i.stop && !sts_i.last_step) begin
          cmd_o.advance = 1'b1;
          state_d       = glv_pkg::ST_MUL;
        end else if (sts_i.last_ray) begin
          state_d = glv_pkg::ST_DONE;
        end else begin
          cmd_o.ray_next = 1'b1;
          state_d        = glv_pkg::ST_RAY_INIT;
        end
      end
      glv_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = glv_pkg::ST_IDLE;
        end
      end
      default: state_d = glv_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/glv_datapath.sv =====
// Datapath of the grid visibility block: configuration, item registers, grid
// memories, iterative CORDIC, sample mapping and the result register. Depends on glv_pkg.
module glv_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [glv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [glv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [1:0]                       req_type_i,
  input  logic [15:0]                      cell_index_i,
  input  logic                             truth_ground_i,
  input  logic                             truth_air_i,
  input  logic signed [31:0]               pos_x_i,
  input  logic signed [31:0]               pos_y_i,
  input  logic                             robot_is_ground_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       vis_ground_o,
  output logic [1:0]                       vis_air_o,
  output logic                             pose_ignored_o,
  input  glv_pkg::cmd_t                    cmd_i,
  output glv_pkg::status_t                 sts_o
);

  logic [glv_pkg::DIM_W-1:0]  width_q, height_q;
  logic signed [31:0]         origin_x_q, origin_y_q;
  logic [glv_pkg::CPM_W-1:0]  cpm_q;
  logic                       map_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= glv_pkg::DIM_W'(256);
      height_q    <= glv_pkg::DIM_W'(256);
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cpm_q       <= glv_pkg::CPM_W'(65536);
      map_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        glv_pkg::CFG_WIDTH:     width_q     <= cfg_data_i[glv_pkg::DIM_W-1:0];
        glv_pkg::CFG_HEIGHT:    height_q    <= cfg_data_i[glv_pkg::DIM_W-1:0];
        glv_pkg::CFG_ORIGIN_X:  origin_x_q  <= $signed(cfg_data_i);
        glv_pkg::CFG_ORIGIN_Y:  origin_y_q  <= $signed(cfg_data_i);
        glv_pkg::CFG_CPM:       cpm_q       <= cfg_data_i[glv_pkg::CPM_W-1:0];
        glv_pkg::CFG_MAP_VALID: map_valid_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [glv_pkg::WSAT_W-1:0] w_sat;
  logic [glv_pkg::HSAT_W-1:0] h_sat;
  assign w_sat = (int'(width_q) > glv_pkg::MAX_WIDTH) ? glv_pkg::WSAT_W'(glv_pkg::MAX_WIDTH)
                                                      : glv_pkg::WSAT_W'(width_q);
  assign h_sat = (int'(height_q) > glv_pkg::MAX_HEIGHT) ? glv_pkg::HSAT_W'(glv_pkg::MAX_HEIGHT)
                                                        : glv_pkg::HSAT_W'(height_q);

  // Item registers.
  glv_pkg::req_e              type_q;
  logic                       idx_ok_q;
  logic                       tg_q, ta_q, ground_q;
  logic signed [31:0]         pos_x_q, pos_y_q;
  logic [glv_pkg::ADDR_W-1:0] idx_q;

  logic [glv_pkg::ADDR_W-1:0] idx_calc;
  logic                       inb_calc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q   <= glv_pkg::req_e'(req_type_i);
      idx_ok_q <= int'(cell_index_i) < glv_pkg::GRID_CELLS;
      idx_q    <= glv_pkg::ADDR_W'(cell_index_i);
      tg_q     <= truth_ground_i;
      ta_q     <= truth_air_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      ground_q <= robot_is_ground_i;
    end else if (cmd_i.index) begin
      idx_q <= idx_calc;
    end
  end

  // Clearing pass counter.
  logic [glv_pkg::ADDR_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + glv_pkg::ADDR_W'(1);
    end
  end

  // Ray angle, ray and step counters.
  logic [31:0]                ang_q;
  logic [glv_pkg::REM_W-1:0]  rem_q, rem_sum;
  logic [glv_pkg::RAY_W-1:0]  ray_q;
  logic [glv_pkg::STEP_W-1:0] step_q;
  assign rem_sum = rem_q + glv_pkg::ANG_REM;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pose_start) begin
      ang_q <= '0;
      rem_q <= '0;
      ray_q <= '0;
    end else if (cmd_i.ray_next) begin
      ray_q <= ray_q + glv_pkg::RAY_W'(1);
      if (int'(rem_sum) >= glv_pkg::RAY_COUNT) begin
        rem_q <= rem_sum - glv_pkg::REM_W'(glv_pkg::RAY_COUNT);
        ang_q <= ang_q + glv_pkg::ANG_STEP + 32'd1;
      end else begin
        rem_q <= rem_sum;
        ang_q <= ang_q + glv_pkg::ANG_STEP;
      end
    end
  end

  // Iterative CORDIC rotation, one micro-rotation per cycle.
  logic signed [glv_pkg::CX_W-1:0]  cx_q, cy_q, cxs, cys, cxr, cyr, cxf, cyf;
  logic signed [31:0]               cz_q;
  logic [glv_pkg::K_W-1:0]          k_q;
  logic signed [glv_pkg::DIR_W-1:0] c_q, s_q, cr, sr;

  assign cxs = cx_q >>> k_q;
  assign cys = cy_q >>> k_q;
  assign cxr = cx_q + glv_pkg::ROUND_HALF;
  assign cyr = cy_q + glv_pkg::ROUND_HALF;
  assign cxf = cxr >>> 14;
  assign cyf = cyr >>> 14;
  assign cr  = cxf[glv_pkg::DIR_W-1:0];
  assign sr  = cyf[glv_pkg::DIR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ray_init) begin
      cx_q <= glv_pkg::CORDIC_GAIN;
      cy_q <= '0;
      cz_q <= $signed({2'b00, ang_q[29:0]});
      k_q  <= '0;
    end else if (cmd_i.rotate) begin
      k_q <= k_q + glv_pkg::K_W'(1);
      if (!cz_q[31]) begin
        cx_q <= cx_q - cys;
        cy_q <= cy_q + cxs;
        cz_q <= cz_q - $signed(glv_pkg::ATAN_TURNS[k_q]);
      end else begin
        cx_q <= cx_q + cys;
        cy_q <= cy_q - cxs;
        cz_q <= cz_q + $signed(glv_pkg::ATAN_TURNS[k_q]);
      end
    end
    if (cmd_i.dir) begin
      unique case (ang_q[31:30])
        2'd0: begin c_q <= cr;  s_q <= sr;  end
        2'd1: begin c_q <= -sr; s_q <= cr;  end
        2'd2: begin c_q <= -cr; s_q <= -sr; end
        default: begin c_q <= sr; s_q <= -cr; end
      endcase
    end
  end

  // Sample position relative to the grid corner, products and cell index.
  logic signed [glv_pkg::POS_W-1:0]  px_q, py_q;
  logic signed [glv_pkg::PROD_W-1:0] prx_q, pry_q;
  logic signed [glv_pkg::CPM_W:0]    cpm_s;
  logic [glv_pkg::GX_W-1:0]          gx, gy;
  logic                              gx_ok, gy_ok, inb_q;
  assign cpm_s = $signed({1'b0, cpm_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.ray_init) begin
      px_q   <= glv_pkg::POS_W'(pos_x_q) - glv_pkg::POS_W'(origin_x_q);
      py_q   <= glv_pkg::POS_W'(pos_y_q) - glv_pkg::POS_W'(origin_y_q);
      step_q <= '0;
    end else if (cmd_i.advance) begin
      px_q   <= px_q + glv_pkg::POS_W'(c_q);
      py_q   <= py_q + glv_pkg::POS_W'(s_q);
      step_q <= step_q + glv_pkg::STEP_W'(1);
    end
    if (cmd_i.mul) begin
      prx_q <= px_q * cpm_s;
      pry_q <= py_q * cpm_s;
    end
    if (cmd_i.index) begin
      inb_q <= inb_calc;
    end
  end

  assign gx = prx_q[glv_pkg::PROD_W-1:32]
            + glv_pkg::GX_W'(prx_q[glv_pkg::PROD_W-1] && (|prx_q[31:0]));
  assign gy = pry_q[glv_pkg::PROD_W-1:32]
            + glv_pkg::GX_W'(pry_q[glv_pkg::PROD_W-1] && (|pry_q[31:0]));
  assign gx_ok    = !gx[glv_pkg::GX_W-1] && (gx < glv_pkg::GX_W'(w_sat));
  assign gy_ok    = !gy[glv_pkg::GX_W-1] && (gy < glv_pkg::GX_W'(h_sat));
  assign inb_calc = gx_ok && gy_ok;
  assign idx_calc = glv_pkg::ADDR_W'(gy[glv_pkg::ROW_W-1:0] * w_sat)
                  + glv_pkg::ADDR_W'(gx);

  // Grid memories: truth bits {air, ground} and visible states {air, ground}.
  logic [1:0] truth_mem [glv_pkg::GRID_CELLS];
  logic [3:0] vis_mem   [glv_pkg::GRID_CELLS];
  logic [1:0] truth_rd_q;
  logic [3:0] vis_rd_q;
  logic [1:0] mark_g, mark_a;
  logic       stop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      truth_mem[clr_q] <= '0;
    end else if (cmd_i.load_write && idx_ok_q) begin
      truth_mem[idx_q] <= {ta_q, tg_q};
    end
    truth_rd_q <= truth_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      vis_mem[clr_q] <= '0;
    end else if (cmd_i.mark) begin
      vis_mem[idx_q] <= {mark_a, mark_g};
    end
    vis_rd_q <= vis_mem[idx_q];
  end

  always_comb begin
    if (ground_q) begin
      stop   = truth_rd_q[0];
      mark_g = truth_rd_q[0] ? glv_pkg::VIS_OCC : glv_pkg::VIS_FREE;
      mark_a = (truth_rd_q[0] && truth_rd_q[1]) ? glv_pkg::VIS_OCC : glv_pkg::VIS_FREE;
    end else begin
      stop   = truth_rd_q[1];
      mark_g = (truth_rd_q[1] || truth_rd_q[0]) ? glv_pkg::VIS_OCC : glv_pkg::VIS_FREE;
      mark_a = truth_rd_q[1] ? glv_pkg::VIS_OCC : glv_pkg::VIS_FREE;
    end
  end

  // Result register.
  logic       out_valid_q;
  logic [1:0] res_g_q, res_a_q;
  logic       res_ign_q;
  logic       is_read;
  assign is_read = (type_q == glv_pkg::REQ_READ) && idx_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_g_q   <= is_read ? vis_rd_q[1:0] : glv_pkg::VIS_UNKNOWN;
      res_a_q   <= is_read ? vis_rd_q[3:2] : glv_pkg::VIS_UNKNOWN;
      res_ign_q <= (type_q == glv_pkg::REQ_POSE) && !map_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vis_ground_o   = res_g_q;
  assign vis_air_o      = res_a_q;
  assign pose_ignored_o = res_ign_q;

  always_comb begin
    sts_o.clear_last  = clr_q == glv_pkg::ADDR_W'(glv_pkg::GRID_CELLS - 1);
    sts_o.req_type    = type_q;
    sts_o.map_valid   = map_valid_q;
    sts_o.cordic_last = int'(k_q) == glv_pkg::CORDIC_STEPS - 1;
    sts_o.inb         = inb_q;
    sts_o.stop        = stop;
    sts_o.last_step   = int'(step_q) == glv_pkg::RANGE_STEPS;
    sts_o.last_ray    = int'(ray_q) == glv_pkg::RAY_COUNT - 1;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

// ===== rtl/core/grid_lidar_visibility_raycast.sv =====
// Top level of the grid visibility block: joins controller and datapath.
// Depends on glv_pkg, glv_ctrl, glv_datapath and assert_macros.svh.
//
// After reset the block clears both grids, one cell a cycle, and accepts no
// transaction until then; configuration writes are taken at any time. A load
// passes the dispatch, load and done states and a read the dispatch, read and
// done states up to the result register. A pose walks 120 rays; each ray runs
// the iterative CORDIC unit (init, rotate, direction) and then, for up to 13
// samples, the sample loop (multiply, index, memory read, mark). The next
// transaction is taken while a finished result waits in the output register.
`include "assert_macros.svh"
module grid_lidar_visibility_raycast (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [glv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [glv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [15:0]                    cell_index_i,
  input  logic                           truth_ground_i,
  input  logic                           truth_air_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic                           robot_is_ground_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     vis_ground_o,
  output logic [1:0]                     vis_air_o,
  output logic                           pose_ignored_o
);

  glv_pkg::cmd_t    cmd;
  glv_pkg::status_t sts;

  glv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glv_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (req_type_i),
    .cell_index_i      (cell_index_i),
    .truth_ground_i    (truth_ground_i),
    .truth_air_i       (truth_air_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .robot_is_ground_i (robot_is_ground_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .vis_ground_o      (vis_ground_o),
    .vis_air_o         (vis_air_o),
    .pose_ignored_o    (pose_ignored_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

  `ASSERT_RST(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `ASSERT_RST(a_res_slot_free, clk_i, rst_ni, cmd.res_load |-> sts.out_free)
  `ASSERT_ALWAYS(a_clear_blocks, clk_i, cmd.clear_en |-> !in_ready_o)
  `ASSERT_RST(a_ignored_zero, clk_i, rst_ni, (out_valid_o && pose_ignored_o) |-> !(|{vis_ground_o, vis_air_o}))

endmodule
